[src/rmws_pkg.sv]
// Shared constants and types for the row minimum window sum block.
// Used by every module under src; depends on nothing.
package rmws_pkg;

  localparam int unsigned MAX_WINDOW = 1024;
  localparam int unsigned ADDR_W     = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned LEN_RESET  = 64;

  typedef struct packed {
    logic act;
    logic full;
    logic fills;
    logic last;
  } rmws_flags_t;

endpackage

[src/rmws_ring.sv]
// Pixel ring memory with a registered read that returns the old contents.
// Depends on rmws_pkg.
module rmws_ring (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rmws_pkg::ADDR_W-1:0] addr,
  input  logic [rmws_pkg::PIX_W-1:0]  wdata,
  output logic [rmws_pkg::PIX_W-1:0]  rdata
);
  import rmws_pkg::*;

  logic [PIX_W-1:0] ring_mem [MAX_WINDOW];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r       <= ring_mem[addr];
      ring_mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

[src/rmws_ctrl.sv]
// Window length register, ring position and fill tracking for each request.
// Depends on rmws_pkg; drives the ring memory and the accumulator stage.
module rmws_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rmws_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                        accept,
  input  logic                        in_ready,
  input  logic [rmws_pkg::PIX_W-1:0]  pixel,
  input  logic                        last_in_row,
  output logic                        ring_en,
  output logic [rmws_pkg::ADDR_W-1:0] ring_addr,
  output logic                        s1_valid,
  output rmws_pkg::rmws_flags_t       s1_flags,
  output logic [rmws_pkg::PIX_W-1:0]  s1_pixel
);
  import rmws_pkg::*;

  logic [LEN_W-1:0]  cfg_len_r;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic              full_r, full_nxt;
  logic              s1_valid_r;
  rmws_flags_t       s1_flags_r, flags;
  logic [PIX_W-1:0]  s1_pixel_r;
  logic [LEN_W-1:0]  len_eff, pos_inc;
  logic              wrap;

  assign len_eff = (cfg_len_r > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : cfg_len_r;
  assign pos_inc = {1'b0, pos_r} + LEN_W'(1);
  assign wrap    = pos_inc >= len_eff;

  always_comb begin
    flags.act   = len_eff != '0;
    flags.full  = full_r;
    flags.fills = flags.act && !full_r && wrap;
    flags.last  = last_in_row;
  end

  always_comb begin
    pos_nxt  = pos_r;
    full_nxt = full_r;
    if (cfg_wr_en) begin
      pos_nxt  = '0;
      full_nxt = 1'b0;
    end else if (accept) begin
      if (flags.act) begin
        pos_nxt  = wrap ? '0 : pos_inc[ADDR_W-1:0];
        full_nxt = full_r | wrap;
      end
      if (last_in_row) begin
        pos_nxt  = '0;
        full_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r  <= LEN_W'(LEN_RESET);
      pos_r      <= '0;
      full_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
      pos_r  <= pos_nxt;
      full_r <= full_nxt;
      if (in_ready) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r <= flags;
      s1_pixel_r <= pixel;
    end
  end

  assign ring_en   = accept && flags.act;
  assign ring_addr = pos_r;
  assign s1_valid  = s1_valid_r;
  assign s1_flags  = s1_flags_r;
  assign s1_pixel  = s1_pixel_r;

`ifndef SYNTHESIS
  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (len_eff != '0) |-> ({1'b0, pos_r} < len_eff))
    else $error("ring position beyond window length");

  a_fill_once: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !(s1_flags_r.fills && s1_flags_r.full))
    else $error("window filled twice in one row");
`endif

endmodule

[src/rmws_accum.sv]
// Running sum, row minimum and result register.
// Depends on rmws_pkg; fed by rmws_ctrl and rmws_ring.
module rmws_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       s1_valid,
  input  rmws_pkg::rmws_flags_t      s1_flags,
  input  logic [rmws_pkg::PIX_W-1:0] s1_pixel,
  input  logic [rmws_pkg::PIX_W-1:0] old_pixel,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [rmws_pkg::SUM_W-1:0] out_sum,
  output logic                       stall
);
  import rmws_pkg::*;

  logic [SUM_W-1:0] sum_r, sum_nxt, best_r, best_nxt, res_r, res;
  logic             out_valid_r;
  logic             adv;

  assign stall = s1_valid && s1_flags.last && out_valid_r && !out_ready;
  assign adv   = s1_valid && !stall;

  always_comb begin
    sum_nxt  = sum_r;
    best_nxt = best_r;
    if (s1_flags.act) begin
      if (!s1_flags.full) begin
        sum_nxt = sum_r + SUM_W'(s1_pixel);
        if (s1_flags.fills) begin
          best_nxt = sum_nxt;
        end
      end else begin
        sum_nxt = sum_r + SUM_W'(s1_pixel) - SUM_W'(old_pixel);
        if (sum_nxt < best_r) begin
          best_nxt = sum_nxt;
        end
      end
    end
    res = (s1_flags.full || s1_flags.fills) ? best_nxt : sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sum_r  <= '0;
        best_r <= '0;
      end else if (adv) begin
        sum_r  <= s1_flags.last ? '0 : sum_nxt;
        best_r <= s1_flags.last ? '0 : best_nxt;
      end
      if (adv && s1_flags.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_flags.last) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_sum   = res_r;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_flags.last) |=> out_valid_r)
    else $error("row end gave no result");

  a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_flags.last && !cfg_wr_en) |=> (sum_r == '0 && best_r == '0))
    else $error("row state not cleared after row end");
`endif

endmodule

[src/row_min_window_sum.sv]
// Row minimum window sum: top level joining control, ring memory and accumulator.
// Depends on rmws_pkg, rmws_ctrl, rmws_ring and rmws_accum.
//
// Pixels of one row enter one per cycle; on the pixel marked last the block
// returns the least sum over any window_length consecutive pixels of the row,
// or the sum of all the row's pixels if the row was shorter than the window.
// Window lengths above 1024 act as 1024 and a length of 0 yields 0. A request
// is registered together with the ring memory read and write on the accept edge,
// then updates the sum, minimum and result registers when the stage is not stalled.
// One request is accepted every cycle; input stalls only when a row end meets
// a result still waiting at the output. Write the window length only while
// idle; the write starts a new row.
module row_min_window_sum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [10:0]      cfg_wr_data,  // window_length
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,     // [7:0] pixel
  input  logic             in_tlast,     // last_in_row
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata     // [17:0] min_window_sum, [23:18] zero
);
  import rmws_pkg::*;

  logic                 accept;
  logic                 ring_en;
  logic [ADDR_W-1:0]    ring_addr;
  logic [PIX_W-1:0]     old_pixel;
  logic                 s1_valid;
  rmws_flags_t          s1_flags;
  logic [PIX_W-1:0]     s1_pixel;
  logic                 stall;
  logic [SUM_W-1:0]     out_sum;

  assign in_tready = !stall;
  assign accept    = in_tvalid && in_tready;

  rmws_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .in_ready    (in_tready),
    .pixel       (in_tdata),
    .last_in_row (in_tlast),
    .ring_en     (ring_en),
    .ring_addr   (ring_addr),
    .s1_valid    (s1_valid),
    .s1_flags    (s1_flags),
    .s1_pixel    (s1_pixel)
  );

  rmws_ring u_ring (
    .clk   (clk),
    .en    (ring_en),
    .addr  (ring_addr),
    .wdata (in_tdata),
    .rdata (old_pixel)
  );

  rmws_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .s1_valid  (s1_valid),
    .s1_flags  (s1_flags),
    .s1_pixel  (s1_pixel),
    .old_pixel (old_pixel),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_sum   (out_sum),
    .stall     (stall)
  );

  assign out_tdata = {6'b0, out_sum};

endmodule
